### rtl/bsp_pkg.sv
package bsp_pkg;

	localparam int unsigned MAX_DEPTH = 16;
	localparam int unsigned LVL_W     = $clog2(MAX_DEPTH + 1);
	localparam int unsigned ADDR_W    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int unsigned NEST_W    = 5;

	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [7:0] CH_L     = 8'h6C;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_E     = 8'h65;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;

	localparam logic [31:0] MAG_CAP = 32'h8000_0000;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_INT_FIRST,
		MODE_INT,
		MODE_LEN,
		MODE_BODY,
		MODE_ERR
	} mode_t;

	typedef enum logic [3:0] {
		EV_HEADER,
		EV_INT,
		EV_LEN,
		EV_BODY,
		EV_LIST,
		EV_DICT,
		EV_CLOSE,
		EV_ERROR,
		EV_IGNORED
	} ev_t;

	typedef enum logic [2:0] {
		ERR_NONE,
		ERR_LEAD,
		ERR_DIGIT,
		ERR_INT,
		ERR_LEN,
		ERR_TRUNC,
		ERR_DEEP
	} err_t;

	typedef struct packed {
		logic val;
		logic dict;
	} level_t;

	typedef struct packed {
		logic ovf;
		logic digit;
		logic neg;
	} flags_t;

	typedef struct packed {
		mode_t              mode;
		logic [LVL_W-1:0]   count;
		level_t             top;
		logic [31:0]        accum;
		flags_t             flags;
		logic [30:0]        remaining;
	} state_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		level_t            data;
	} ram_wr_t;

	typedef struct packed {
		ev_t                event_res;
		logic signed [31:0] int_value;
		logic [30:0]        str_length;
		logic [7:0]         body_byte;
		logic               string_done;
		logic [NEST_W-1:0]  nest_level;
		logic               value_done;
		err_t               error_code;
	} result_t;

endpackage

### rtl/bsp_ram.sv
module bsp_ram #(
	parameter int unsigned WIDTH = 2,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/bsp_decode.sv
module bsp_decode (
	input  bsp_pkg::state_t  st,
	input  bsp_pkg::level_t  below,
	input  logic [7:0]       data_byte,
	input  logic             end_of_buffer,
	output bsp_pkg::state_t  nx,
	output bsp_pkg::result_t res,
	output bsp_pkg::ram_wr_t wr
);

	localparam int unsigned LVL_W  = bsp_pkg::LVL_W;
	localparam int unsigned ADDR_W = bsp_pkg::ADDR_W;
	localparam int unsigned NEST_W = bsp_pkg::NEST_W;

	logic              is_dig;
	logic [3:0]        dig;
	logic [34:0]       prod;
	logic              acc_ovf;
	logic [31:0]       acc_next;
	logic              int_ok;
	logic              len_ok;
	logic [30:0]       rem_dec;
	logic              full;
	bsp_pkg::mode_t    mode_a;
	bsp_pkg::err_t     err_c;
	logic              fin;
	logic              pop;
	bsp_pkg::level_t   base_top;
	logic              trunc;

	assign is_dig   = (data_byte >= bsp_pkg::CH_0) && (data_byte <= bsp_pkg::CH_9);
	assign dig      = 4'(data_byte - bsp_pkg::CH_0);
	assign prod     = {3'b000, st.accum} * 35'd10 + {31'd0, dig};
	assign acc_ovf  = prod > {3'b000, bsp_pkg::MAG_CAP};
	assign acc_next = acc_ovf ? bsp_pkg::MAG_CAP : prod[31:0];
	assign int_ok   = st.flags.digit && !st.flags.ovf &&
		(st.flags.neg ? (st.accum <= bsp_pkg::MAG_CAP) : (st.accum < bsp_pkg::MAG_CAP));
	assign len_ok   = !st.flags.ovf && !st.accum[31];
	assign rem_dec  = (st.remaining != 31'd0) ? st.remaining - 31'd1 : st.remaining;
	assign full     = st.count >= LVL_W'(bsp_pkg::MAX_DEPTH);

	// next parse mode and error detection
	always_comb begin
		mode_a = st.mode;
		err_c  = bsp_pkg::ERR_NONE;
		unique case (st.mode) inside
			bsp_pkg::MODE_IDLE: begin
				if (data_byte == bsp_pkg::CH_I) begin
					mode_a = bsp_pkg::MODE_INT_FIRST;
				end else if (is_dig) begin
					mode_a = bsp_pkg::MODE_LEN;
				end else if (data_byte == bsp_pkg::CH_L || data_byte == bsp_pkg::CH_D) begin
					if (full) begin
						err_c = bsp_pkg::ERR_DEEP;
					end
				end else if (data_byte == bsp_pkg::CH_E) begin
					if (st.count == '0 || st.top.val) begin
						err_c = bsp_pkg::ERR_LEAD;
					end
				end else begin
					err_c = bsp_pkg::ERR_LEAD;
				end
			end
			bsp_pkg::MODE_INT_FIRST, bsp_pkg::MODE_INT: begin
				if (data_byte == bsp_pkg::CH_MINUS && st.mode == bsp_pkg::MODE_INT_FIRST) begin
					mode_a = bsp_pkg::MODE_INT;
				end else if (is_dig) begin
					mode_a = bsp_pkg::MODE_INT;
				end else if (data_byte == bsp_pkg::CH_E) begin
					if (int_ok) begin
						mode_a = bsp_pkg::MODE_IDLE;
					end else begin
						err_c = bsp_pkg::ERR_INT;
					end
				end else begin
					err_c = bsp_pkg::ERR_DIGIT;
				end
			end
			bsp_pkg::MODE_LEN: begin
				if (is_dig) begin
					mode_a = bsp_pkg::MODE_LEN;
				end else if (data_byte == bsp_pkg::CH_COLON) begin
					if (!len_ok) begin
						err_c = bsp_pkg::ERR_LEN;
					end else if (st.accum == 32'd0) begin
						mode_a = bsp_pkg::MODE_IDLE;
					end else begin
						mode_a = bsp_pkg::MODE_BODY;
					end
				end else begin
					err_c = bsp_pkg::ERR_DIGIT;
				end
			end
			bsp_pkg::MODE_BODY: begin
				if (rem_dec == 31'd0) begin
					mode_a = bsp_pkg::MODE_IDLE;
				end
			end
			bsp_pkg::MODE_ERR: begin
				mode_a = bsp_pkg::MODE_ERR;
			end
			default: begin
				mode_a = bsp_pkg::MODE_ERR;
			end
		endcase
		if (err_c != bsp_pkg::ERR_NONE) begin
			mode_a = bsp_pkg::MODE_ERR;
		end
	end

	// result fields, datapath and stack updates
	always_comb begin
		nx       = st;
		nx.mode  = mode_a;
		res      = '0;
		res.event_res  = bsp_pkg::EV_IGNORED;
		res.error_code = bsp_pkg::ERR_NONE;
		wr       = '0;
		fin      = 1'b0;
		pop      = 1'b0;
		base_top = st.top;
		trunc    = 1'b0;
		if (err_c != bsp_pkg::ERR_NONE) begin
			res.event_res  = bsp_pkg::EV_ERROR;
			res.error_code = err_c;
		end else begin
			case (st.mode)
				bsp_pkg::MODE_IDLE: begin
					if (data_byte == bsp_pkg::CH_I) begin
						res.event_res = bsp_pkg::EV_HEADER;
						nx.accum      = '0;
						nx.flags      = '0;
					end else if (is_dig) begin
						res.event_res  = bsp_pkg::EV_HEADER;
						nx.accum       = {28'd0, dig};
						nx.flags       = '0;
						nx.flags.digit = 1'b1;
					end else if (data_byte == bsp_pkg::CH_L || data_byte == bsp_pkg::CH_D) begin
						// spill the current top into the stack memory
						wr.en        = st.count != '0;
						wr.addr      = ADDR_W'(st.count - LVL_W'(1));
						wr.data      = st.top;
						nx.top.dict  = data_byte == bsp_pkg::CH_D;
						nx.top.val   = 1'b0;
						nx.count     = st.count + LVL_W'(1);
						res.event_res = (data_byte == bsp_pkg::CH_D) ?
							bsp_pkg::EV_DICT : bsp_pkg::EV_LIST;
					end else if (data_byte == bsp_pkg::CH_E) begin
						nx.count      = st.count - LVL_W'(1);
						res.event_res = bsp_pkg::EV_CLOSE;
						pop           = 1'b1;
						fin           = 1'b1;
					end
				end
				bsp_pkg::MODE_INT_FIRST, bsp_pkg::MODE_INT: begin
					if (data_byte == bsp_pkg::CH_MINUS && st.mode == bsp_pkg::MODE_INT_FIRST) begin
						nx.flags.neg  = 1'b1;
						res.event_res = bsp_pkg::EV_HEADER;
					end else if (is_dig) begin
						nx.accum       = acc_next;
						nx.flags.digit = 1'b1;
						nx.flags.ovf   = st.flags.ovf | acc_ovf;
						res.event_res  = bsp_pkg::EV_HEADER;
					end else begin
						res.event_res = bsp_pkg::EV_INT;
						res.int_value = st.flags.neg ? $signed(32'd0 - st.accum) :
							$signed(st.accum);
						fin           = 1'b1;
					end
				end
				bsp_pkg::MODE_LEN: begin
					if (is_dig) begin
						nx.accum       = acc_next;
						nx.flags.digit = 1'b1;
						nx.flags.ovf   = st.flags.ovf | acc_ovf;
						res.event_res  = bsp_pkg::EV_HEADER;
					end else begin
						res.event_res  = bsp_pkg::EV_LEN;
						res.str_length = st.accum[30:0];
						if (st.accum == 32'd0) begin
							res.string_done = 1'b1;
							fin             = 1'b1;
						end else begin
							nx.remaining = st.accum[30:0];
						end
					end
				end
				bsp_pkg::MODE_BODY: begin
					res.event_res = bsp_pkg::EV_BODY;
					res.body_byte = data_byte;
					nx.remaining  = rem_dec;
					if (rem_dec == 31'd0) begin
						res.string_done = 1'b1;
						fin             = 1'b1;
					end
				end
				default: begin
					res.event_res = bsp_pkg::EV_IGNORED;
				end
			endcase
		end

		// a value ended: flag top level or flip the dictionary slot
		if (pop) begin
			base_top = below;
		end
		if (fin) begin
			if (nx.count == '0) begin
				res.value_done = 1'b1;
			end else begin
				nx.top     = base_top;
				nx.top.val = base_top.val ^ base_top.dict;
			end
		end
		res.nest_level = NEST_W'(nx.count);

		if (end_of_buffer) begin
			trunc = st.mode != bsp_pkg::MODE_ERR && err_c == bsp_pkg::ERR_NONE &&
				(mode_a != bsp_pkg::MODE_IDLE || nx.count != '0);
			if (trunc) begin
				res            = '0;
				res.event_res  = bsp_pkg::EV_ERROR;
				res.error_code = bsp_pkg::ERR_TRUNC;
			end
			res.nest_level = '0;
			nx             = '0;
			nx.mode        = bsp_pkg::MODE_IDLE;
		end
	end

endmodule

### rtl/bsp_outbuf.sv
module bsp_outbuf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_fire,
	input  bsp_pkg::result_t in_res,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	output bsp_pkg::result_t out_res
);

	logic             out_v_q;
	logic             skid_v_q;
	bsp_pkg::result_t out_q;
	bsp_pkg::result_t skid_q;
	logic             take;

	assign take      = out_v_q && !out_stall;
	assign in_stall  = skid_v_q;
	assign out_valid = out_v_q;
	assign out_res   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (take) begin
				skid_v_q <= 1'b0;
			end
		end else if (in_fire) begin
			if (!out_v_q || take) begin
				out_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (take) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (in_fire) begin
			if (!out_v_q || take) begin
				out_q <= in_res;
			end else begin
				skid_q <= in_res;
			end
		end
	end

endmodule

### rtl/bencode_stream_parser.sv
// Bencode tokenizer: one raw byte in, one token event out for every byte.
// Input channel: data_byte with end_of_buffer marking the last byte of a
// buffer, handshaked by in_valid / in_stall. Output channel: event_res and
// its fields, handshaked by out_valid / out_stall.
// Throughput is one byte per cycle while in_stall is low. The top nesting
// level sits in a register and the level below it is kept prefetched from
// the stack memory (one read port, registered read data, forwarded on a
// same-address write), so pushes and pops may follow each other on every
// cycle. A two-entry output buffer (output register plus skid) decouples
// the sides: the event for a byte is registered in the output register,
// or in the skid while it is held; in_stall rises only while both entries
// hold events the receiver has not taken, and falls once one is drained.
// Reset clears the parser to idle at depth zero and empties the buffer. The
// stack memory needs no clearing: only levels that were pushed are read.
// After an error every byte yields an ignored event until the byte marked
// end_of_buffer, which always returns the parser to its reset state.
module bencode_stream_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         data_byte,
	input  logic               end_of_buffer,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [3:0]         event_res,
	output logic signed [31:0] int_value,
	output logic [30:0]        str_length,
	output logic [7:0]         body_byte,
	output logic               string_done,
	output logic [4:0]         nest_level,
	output logic               value_done,
	output logic [2:0]         error_code
);

	localparam int unsigned LVL_W  = bsp_pkg::LVL_W;
	localparam int unsigned ADDR_W = bsp_pkg::ADDR_W;

	bsp_pkg::state_t  st_q;
	bsp_pkg::state_t  nx;
	bsp_pkg::result_t res;
	bsp_pkg::result_t out_res;
	bsp_pkg::ram_wr_t wr;
	bsp_pkg::level_t  below;
	logic [1:0]       rdata;
	logic             in_fire;
	logic [LVL_W-1:0] cnt_n;
	logic [ADDR_W-1:0] raddr;
	logic             fwd_q;
	bsp_pkg::level_t  fwd_data_q;
	logic             wr_en;

	assign in_fire = in_valid && !in_stall;
	assign wr_en   = in_fire && wr.en;

	// keep the level under the top prefetched for the next byte
	assign cnt_n = in_fire ? nx.count : st_q.count;
	assign raddr = ADDR_W'(cnt_n - LVL_W'(2));
	assign below = fwd_q ? fwd_data_q : bsp_pkg::level_t'(rdata);

	bsp_decode u_decode (
		.st            (st_q),
		.below         (below),
		.data_byte     (data_byte),
		.end_of_buffer (end_of_buffer),
		.nx            (nx),
		.res           (res),
		.wr            (wr)
	);

	bsp_ram #(
		.WIDTH (2),
		.DEPTH (bsp_pkg::MAX_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr.addr),
		.wdata (wr.data),
		.raddr (raddr),
		.rdata (rdata)
	);

	bsp_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.in_res    (res),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	// all-zero state is idle at depth zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= '0;
			fwd_q <= 1'b0;
		end else begin
			if (in_fire) begin
				st_q <= nx;
			end
			fwd_q <= wr_en && (wr.addr == raddr);
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= wr.data;
	end

	assign event_res   = out_res.event_res;
	assign int_value   = out_res.int_value;
	assign str_length  = out_res.str_length;
	assign body_byte   = out_res.body_byte;
	assign string_done = out_res.string_done;
	assign nest_level  = out_res.nest_level;
	assign value_done  = out_res.value_done;
	assign error_code  = out_res.error_code;

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.count <= LVL_W'(bsp_pkg::MAX_DEPTH))
		else $error("nesting depth beyond limit");

	a_stall_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output register");

	a_eob_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && end_of_buffer) |=>
			(st_q.count == '0 && st_q.mode == bsp_pkg::MODE_IDLE))
		else $error("parser not idle after end of buffer");

	a_err_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && !end_of_buffer && st_q.mode == bsp_pkg::MODE_ERR) |=>
			($stable(st_q.count) && st_q.mode == bsp_pkg::MODE_ERR))
		else $error("state moved while in error");

	a_push_forward: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && in_fire && !end_of_buffer) |=> fwd_q)
		else $error("pushed level not forwarded to prefetch");

endmodule
